// ===== hdl/jlr_pkg.sv =====
// ----------------------------------------------------------------------------
// jlr_pkg
// Shared types and constants for the one-wire line receiver.
// ----------------------------------------------------------------------------
package jlr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;

    localparam logic [7:0]  SAMPLE_DELAY_RST  = 8'd32;
    localparam logic [6:0]  FRAME_BYTES_RST   = 7'd4;
    localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd480000;

    localparam int ADDR_W = 4;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_SAMPLE_DELAY  = 2'd0;
    localparam logic [1:0] REG_FRAME_BYTES   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    typedef enum logic [5:0] {
        P_IDLE      = 6'b000001,
        P_WAIT_LOW  = 6'b000010,
        P_DELAY     = 6'b000100,
        P_WAIT_HIGH = 6'b001000,
        P_STOP_LOW  = 6'b010000,
        P_STOP_HIGH = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]  sample_delay;
        logic [6:0]  frame_bytes;
        logic [19:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  delay_count;
        logic [2:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [19:0] timeout_count;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
    } t_result;

endpackage

// ===== hdl/jlr_step.sv =====
// ----------------------------------------------------------------------------
// jlr_step
// Next-state and result logic for one line sample.
// ----------------------------------------------------------------------------
module jlr_step #(
    parameter int MAX_FRAME_BYTES = jlr_pkg::MAX_FRAME_BYTES_DEF,
    parameter int CW              = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  jlr_pkg::t_cfg    i_cfg,
    input  jlr_pkg::t_state  i_state,
    input  logic [CW-1:0]    i_byte_count,
    input  logic             i_line,
    input  logic             i_arm,
    output jlr_pkg::t_state  o_state,
    output logic [CW-1:0]    o_byte_count,
    output logic             o_res_valid,
    output jlr_pkg::t_result o_res
);

    localparam logic [7:0] MAX8 = 8'(MAX_FRAME_BYTES);

    logic [19:0]   limit;
    logic [19:0]   tc1;
    logic [7:0]    target;
    logic [7:0]    dc1;
    logic [7:0]    fb8;
    logic [7:0]    eff;
    logic [2:0]    bc1;
    logic [CW-1:0] cnt1;
    logic [7:0]    idx8;

    always_comb begin
        limit  = (i_cfg.timeout_ticks == '0) ? 20'd1 : i_cfg.timeout_ticks;
        target = (i_cfg.sample_delay == '0) ? 8'd1 : i_cfg.sample_delay;
        fb8    = {1'b0, i_cfg.frame_bytes};
        if (fb8 == '0) begin
            eff = 8'd1;
        end else if (fb8 > MAX8) begin
            eff = MAX8;
        end else begin
            eff = fb8;
        end
        tc1  = i_state.timeout_count + 20'd1;
        dc1  = i_state.delay_count + 8'd1;
        bc1  = i_state.bit_count + 3'd1;
        cnt1 = i_byte_count + CW'(1);
        idx8 = 8'(i_byte_count);

        o_state      = i_state;
        o_byte_count = i_byte_count;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_arm) begin
            o_state.phase         = jlr_pkg::P_WAIT_LOW;
            o_state.delay_count   = '0;
            o_state.bit_count     = '0;
            o_state.shift_byte    = '0;
            o_state.timeout_count = '0;
            o_byte_count          = '0;
        end else if (i_state.phase != jlr_pkg::P_IDLE) begin
            o_state.timeout_count = tc1;
            if (tc1 >= limit || tc1 == '0) begin
                o_state.phase = jlr_pkg::P_IDLE;
                o_res_valid   = 1'b1;
                o_res.kind    = jlr_pkg::KIND_ABORT;
            end else begin
                case (i_state.phase)
                    jlr_pkg::P_WAIT_LOW: begin
                        if (!i_line) begin
                            o_state.delay_count = '0;
                            o_state.phase       = jlr_pkg::P_DELAY;
                        end
                    end
                    jlr_pkg::P_DELAY: begin
                        o_state.delay_count = dc1;
                        if (dc1 >= target || dc1 == '0) begin
                            o_state.shift_byte = {i_state.shift_byte[6:0], i_line};
                            o_state.bit_count  = bc1;
                            o_state.phase      = jlr_pkg::P_WAIT_HIGH;
                            if (bc1 == '0) begin
                                o_byte_count     = cnt1;
                                o_res_valid      = 1'b1;
                                o_res.kind       = jlr_pkg::KIND_DATA;
                                o_res.data_byte  = {i_state.shift_byte[6:0], i_line};
                                o_res.byte_index = idx8[5:0];
                                o_res.last       = (8'(cnt1) >= eff);
                            end
                        end
                    end
                    jlr_pkg::P_WAIT_HIGH: begin
                        if (i_line) begin
                            if (i_state.bit_count == '0 && 8'(i_byte_count) >= eff) begin
                                o_state.phase = jlr_pkg::P_STOP_LOW;
                            end else begin
                                o_state.phase = jlr_pkg::P_WAIT_LOW;
                            end
                        end
                    end
                    jlr_pkg::P_STOP_LOW: begin
                        if (!i_line) begin
                            o_state.phase = jlr_pkg::P_STOP_HIGH;
                        end
                    end
                    jlr_pkg::P_STOP_HIGH: begin
                        if (i_line) begin
                            o_state.phase = jlr_pkg::P_IDLE;
                            o_res_valid   = 1'b1;
                            o_res.kind    = jlr_pkg::KIND_DONE;
                        end
                    end
                    default: begin
                        o_state.phase = jlr_pkg::P_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/joybus_line_receiver.sv =====
// ----------------------------------------------------------------------------
// joybus_line_receiver
// Pulse-width coded one-wire frame receiver, one line sample per item.
// ----------------------------------------------------------------------------
// Input stream: one item per line sample, tdata = {arm, line_level}. An arm
// item starts a frame; afterwards each low pulse is timed from its falling
// edge and sampled sample_delay samples later, MSB first.
// Output stream: one item per received byte (tuser kind data, byte and index
// in tdata, tlast on the final byte), one on frame completion after the stop
// bit, and one on watchdog abort after timeout_ticks samples.
// Pipeline: an accepted input item passes through the input register, then
// its result is registered in the result register before it is offered.
// Throughput: one input item per cycle while the result side does not stall;
// the per-sample state update is a single pass of logic between the input
// register and the result register. Reset: synchronous, active low; the
// receiver goes idle, both stages empty, registers return to 32 / 4 / 480000.
// Stall: while a result waits on i_m_tready the pipe holds and o_s_tready
// drops once the input register is full; items without result still move
// through when the result register is empty. The user must write registers
// over the APB port only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module joybus_line_receiver #(
    parameter int MAX_FRAME_BYTES = jlr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [0] line_level, [1] arm
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [15:0]                 o_m_tdata,   // [7:0] data_byte, [13:8] byte_index
    output logic [1:0]                  o_m_tuser,   // [1:0] kind
    output logic                        o_m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jlr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    jlr_pkg::t_cfg    r_cfg;
    jlr_pkg::t_state  r_state;
    jlr_pkg::t_state  n_state;
    logic [CW-1:0]    r_byte_count;
    logic [CW-1:0]    n_byte_count;
    logic             r_in_valid;
    logic             r_in_line;
    logic             r_in_arm;
    logic             r_out_valid;
    jlr_pkg::t_result r_out;
    jlr_pkg::t_result step_res;
    logic             step_valid;
    logic             adv;
    logic             cfg_wr;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb begin
        case (reg_idx)
            jlr_pkg::REG_SAMPLE_DELAY:  prdata = 32'(r_cfg.sample_delay);
            jlr_pkg::REG_FRAME_BYTES:   prdata = 32'(r_cfg.frame_bytes);
            jlr_pkg::REG_TIMEOUT_TICKS: prdata = 32'(r_cfg.timeout_ticks);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_delay  <= jlr_pkg::SAMPLE_DELAY_RST;
            r_cfg.frame_bytes   <= jlr_pkg::FRAME_BYTES_RST;
            r_cfg.timeout_ticks <= jlr_pkg::TIMEOUT_TICKS_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                jlr_pkg::REG_SAMPLE_DELAY:  r_cfg.sample_delay  <= pwdata[7:0];
                jlr_pkg::REG_FRAME_BYTES:   r_cfg.frame_bytes   <= pwdata[6:0];
                jlr_pkg::REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    jlr_step #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CW              (CW)
    ) u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_byte_count (r_byte_count),
        .i_line       (r_in_line),
        .i_arm        (r_in_arm),
        .o_state      (n_state),
        .o_byte_count (n_byte_count),
        .o_res_valid  (step_valid),
        .o_res        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '{phase: jlr_pkg::P_IDLE, default: '0};
            r_byte_count <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_state      <= n_state;
                r_byte_count <= n_byte_count;
            end
            if (adv && step_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_line <= i_s_tdata[0];
            r_in_arm  <= i_s_tdata[1];
        end
        if (adv && step_valid) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.byte_index, r_out.data_byte};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;

endmodule

// ===== hdl/jlr_checker.sv =====
// ----------------------------------------------------------------------------
// jlr_checker
// Port-level checks for the line receiver, bound to the top level.
// ----------------------------------------------------------------------------
module jlr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_m_tready,
    input  logic        i_o_m_tvalid,
    input  logic [15:0] i_o_m_tdata,
    input  logic [1:0]  i_o_m_tuser,
    input  logic        i_o_m_tlast,
    input  logic        i_pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_m_tvalid && !i_m_tready |=> i_o_m_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_m_tvalid && !i_m_tready |=>
            $stable(i_o_m_tdata) && $stable(i_o_m_tuser) && $stable(i_o_m_tlast))
        else $error("result item changed while stalled");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_m_tvalid && i_o_m_tuser != jlr_pkg::KIND_DATA |->
            i_o_m_tdata == '0 && !i_o_m_tlast)
        else $error("status item carries byte fields");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_o_m_tvalid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind joybus_line_receiver jlr_checker u_jlr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_m_tready   (i_m_tready),
    .i_o_m_tvalid (o_m_tvalid),
    .i_o_m_tdata  (o_m_tdata),
    .i_o_m_tuser  (o_m_tuser),
    .i_o_m_tlast  (o_m_tlast),
    .i_pready     (pready)
);

// ===== bench/joybus_line_receiver_chk.sv =====
// ----------------------------------------------------------------------------
// joybus_line_receiver_chk
// Watches the line-sample stream, the result stream and the register port of
// the receiver. Every accepted sample is run through a cycle-free model of the
// receive state machine, and the results it produces are queued in order.
// Each accepted result is compared field by field against the oldest queued
// one. Register writes are tracked so the model always uses the live values.
// ----------------------------------------------------------------------------
module joybus_line_receiver_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [0] line_level, [1] arm
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [15:0]                 i_m_tdata,   // [7:0] data_byte, [13:8] byte_index
    input  logic [1:0]                  i_m_tuser,   // [1:0] kind
    input  logic                        i_m_tlast,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [jlr_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [31:0]                 i_pwdata,
    output int                          o_errors,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  cfg_delay;
    logic [6:0]  cfg_frames;
    logic [19:0] cfg_timeout;

    jlr_pkg::t_phase  rx_phase;
    logic [7:0]  dly_cnt;
    logic [2:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [7:0]  byte_cnt;
    logic [19:0] tmo_cnt;

    jlr_pkg::t_result rx_results_q[$];

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_errors = o_errors + 1;
    endtask

    // one line sample through the receiver; returns 1 when it yields a result
    function automatic bit rx_step(input logic lvl, input logic arm,
                                   output jlr_pkg::t_result res);
        logic [19:0] tmo_lim;
        logic [7:0]  dly_tgt;
        logic [7:0]  flen;
        logic [7:0]  idx;
        res = '0;
        if (arm) begin
            rx_phase = jlr_pkg::P_WAIT_LOW;
            dly_cnt  = '0;
            bit_cnt  = '0;
            shreg    = '0;
            byte_cnt = '0;
            tmo_cnt  = '0;
            return 1'b0;
        end
        if (rx_phase == jlr_pkg::P_IDLE)
            return 1'b0;

        tmo_lim = (cfg_timeout == '0) ? 20'd1 : cfg_timeout;
        tmo_cnt = tmo_cnt + 20'd1;
        if (tmo_cnt >= tmo_lim || tmo_cnt == '0) begin
            rx_phase = jlr_pkg::P_IDLE;
            res.kind = jlr_pkg::KIND_ABORT;
            return 1'b1;
        end

        flen = (cfg_frames == '0) ? 8'd1 :
               (cfg_frames > jlr_pkg::MAX_FRAME_BYTES_DEF) ?
                   8'(jlr_pkg::MAX_FRAME_BYTES_DEF) :
               {1'b0, cfg_frames};

        case (rx_phase)
            jlr_pkg::P_WAIT_LOW: begin
                if (!lvl) begin
                    dly_cnt  = '0;
                    rx_phase = jlr_pkg::P_DELAY;
                end
            end
            jlr_pkg::P_DELAY: begin
                dly_tgt = (cfg_delay == '0) ? 8'd1 : cfg_delay;
                dly_cnt = dly_cnt + 8'd1;
                if (dly_cnt >= dly_tgt || dly_cnt == '0) begin
                    shreg    = {shreg[6:0], lvl};
                    bit_cnt  = bit_cnt + 3'd1;
                    rx_phase = jlr_pkg::P_WAIT_HIGH;
                    if (bit_cnt == '0) begin
                        idx            = byte_cnt;
                        byte_cnt       = byte_cnt + 8'd1;
                        res.kind       = jlr_pkg::KIND_DATA;
                        res.data_byte  = shreg;
                        res.byte_index = idx[5:0];
                        res.last       = (byte_cnt >= flen);
                        return 1'b1;
                    end
                end
            end
            jlr_pkg::P_WAIT_HIGH: begin
                if (lvl) begin
                    if (bit_cnt == '0 && byte_cnt >= flen)
                        rx_phase = jlr_pkg::P_STOP_LOW;
                    else
                        rx_phase = jlr_pkg::P_WAIT_LOW;
                end
            end
            jlr_pkg::P_STOP_LOW: begin
                if (!lvl)
                    rx_phase = jlr_pkg::P_STOP_HIGH;
            end
            jlr_pkg::P_STOP_HIGH: begin
                if (lvl) begin
                    rx_phase = jlr_pkg::P_IDLE;
                    res.kind = jlr_pkg::KIND_DONE;
                    return 1'b1;
                end
            end
            default: rx_phase = jlr_pkg::P_IDLE;
        endcase
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        jlr_pkg::t_result want;
        jlr_pkg::t_result nxt;
        if (!i_rst_n) begin
            o_errors    = 0;
            cfg_delay   = jlr_pkg::SAMPLE_DELAY_RST;
            cfg_frames  = jlr_pkg::FRAME_BYTES_RST;
            cfg_timeout = jlr_pkg::TIMEOUT_TICKS_RST;
            rx_phase    = jlr_pkg::P_IDLE;
            dly_cnt     = '0;
            bit_cnt     = '0;
            shreg       = '0;
            byte_cnt    = '0;
            tmo_cnt     = '0;
            rx_results_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (rx_results_q.size() == 0) begin
                    report($sformatf("unexpected result kind %0d data %02h index %0d last %0b",
                                     i_m_tuser, i_m_tdata[7:0], i_m_tdata[13:8], i_m_tlast));
                end else begin
                    want = rx_results_q.pop_front();
                    if (i_m_tuser !== want.kind)
                        report($sformatf("kind %0d, want %0d", i_m_tuser, want.kind));
                    if (i_m_tdata[7:0] !== want.data_byte)
                        report($sformatf("data_byte %02h, want %02h",
                                         i_m_tdata[7:0], want.data_byte));
                    if (i_m_tdata[13:8] !== want.byte_index)
                        report($sformatf("byte_index %0d, want %0d",
                                         i_m_tdata[13:8], want.byte_index));
                    if (i_m_tlast !== want.last)
                        report($sformatf("last %0b, want %0b", i_m_tlast, want.last));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (rx_step(i_s_tdata[0], i_s_tdata[1], nxt))
                    rx_results_q.push_back(nxt);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    jlr_pkg::REG_SAMPLE_DELAY:  cfg_delay   = i_pwdata[7:0];
                    jlr_pkg::REG_FRAME_BYTES:   cfg_frames  = i_pwdata[6:0];
                    jlr_pkg::REG_TIMEOUT_TICKS: cfg_timeout = i_pwdata[19:0];
                    default: ;
                endcase
            end
        end
        o_pending <= rx_results_q.size();
    end

endmodule

// ===== bench/joybus_line_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// joybus_line_receiver_tb
// Drives pulse-width coded frames into the one-wire receiver, one line sample
// per item, over a series of register settings: full and truncated frames,
// restarts by arm, watchdog aborts, noise, and the register extremes. Both
// stream sides idle in random bursts except in the closing phase. Checking is
// done by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module joybus_line_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata  = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [15:0]                   o_m_tdata;
    logic [1:0]                    o_m_tuser;
    logic                          o_m_tlast;
    logic                          psel       = 1'b0;
    logic                          penable    = 1'b0;
    logic                          pwrite     = 1'b0;
    logic [jlr_pkg::ADDR_W-1:0]    paddr      = '0;
    logic [31:0]                   pwdata     = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    bit                    stall_en   = 1'b1;
    int unsigned           eff_delay  = 32;
    int                    chk_errors;
    int                    chk_pending;
    int                    quiet_cyc  = 0;

    joybus_line_receiver u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    joybus_line_receiver_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .i_m_tlast  (o_m_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side back-pressure
    initial begin
        forever begin
            if (stall_en && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (psel && penable && pready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic lvl, input logic arm);
        if (stall_en && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, arm, lvl};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // high gap, falling edge, then the sample point eff_delay items later
    task automatic send_bit(input logic b);
        int hi_n;
        int lo_n;
        int extra;
        int k;
        hi_n  = $urandom_range(1, 2);
        lo_n  = $urandom_range(0, eff_delay - 1);
        extra = b ? 0 : $urandom_range(0, 2);
        repeat (hi_n) send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        for (k = 1; k <= eff_delay; k++)
            send_item((k == eff_delay) ? b : (b && k > lo_n), 1'b0);
        repeat (extra) send_item(1'b0, 1'b0);
    endtask

    task automatic send_stop();
        repeat ($urandom_range(1, 2)) send_item(1'b1, 1'b0);
        repeat ($urandom_range(1, 3)) send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
    endtask

    task automatic send_frame(input int nbytes);
        logic [7:0] v;
        int i;
        send_item(1'($urandom_range(0, 1)), 1'b1);
        repeat (nbytes) begin
            v = 8'($urandom_range(0, 255));
            for (i = 7; i >= 0; i--)
                send_bit(v[i]);
        end
        send_stop();
    endtask

    task automatic send_partial(input int nbits);
        send_item(1'($urandom_range(0, 1)), 1'b1);
        repeat (nbits) send_bit(1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_item(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    endtask

    task automatic drain_pipe();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic load_cfg(input logic [7:0] dly, input logic [6:0] nbytes,
                            input logic [19:0] tmo);
        drain_pipe();
        reg_write(jlr_pkg::REG_SAMPLE_DELAY, {24'd0, dly});
        reg_write(jlr_pkg::REG_FRAME_BYTES, {25'd0, nbytes});
        reg_write(jlr_pkg::REG_TIMEOUT_TICKS, {12'd0, tmo});
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        eff_delay = (dly == '0) ? 1 : dly;
    endtask

    initial begin
        logic [7:0] pat;
        int i;
        int sel;
        pat = 8'hA5;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle samples are ignored; arm, then a bit under way at reset timing
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        // shorter delay mid-bit: sampled on the next item
        load_cfg(8'd0, 7'd0, 20'hFFFFF);
        send_item(pat[7], 1'b0);
        for (i = 6; i >= 0; i--)
            send_bit(pat[i]);
        send_stop();
        // zero timeout aborts on the first sample after arm
        load_cfg(8'd1, 7'd1, 20'd0);
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);

        load_cfg(8'd1, 7'd2, 20'hFFFFF);
        repeat (3) send_frame($urandom_range(1, 3));

        // watchdog runs out during the longest sample delay
        load_cfg(8'd255, 7'd1, 20'd200);
        send_partial(1);

        // oversized frame length, frame left open
        load_cfg(8'd0, 7'd127, 20'hFFFFF);
        send_frame(2);

        load_cfg(8'd3, 7'd64, 20'd120);
        repeat (2) send_frame(3);

        load_cfg(8'd4, 7'd2, 20'd1);
        send_noise(30);

        load_cfg(8'd5, 7'd3, 20'd480000);
        repeat (4) begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                send_frame($urandom_range(1, 4));
            else if (sel < 8)
                send_partial($urandom_range(1, 12));
            else
                send_noise($urandom_range(5, 15));
        end

        stall_en = 1'b0;
        load_cfg(8'd2, 7'd2, 20'd480000);
        repeat (3) send_frame(2);

        drain_pipe();
        if (chk_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/jlr_pkg.sv
hdl/jlr_step.sv
hdl/joybus_line_receiver.sv
hdl/jlr_checker.sv
bench/joybus_line_receiver_chk.sv
bench/joybus_line_receiver_tb.sv
